/* rtl/htfe_pkg.sv */
// Shared types, constants and helper functions for the header/tail frame extractor.
// No dependencies; htfe_cfg, htfe_core, htfe_obuf, the top and the bench import this package.
package htfe_pkg;

    // Largest frame held before a missing tail is declared an error
    localparam int unsigned MAX_FRAME_BYTES = 256;
    localparam int unsigned PosW            = 8;
    localparam int unsigned CfgIdxW         = 2;
    localparam int unsigned CfgDataW        = 8;

    typedef logic [7:0]         t_byte;
    typedef logic [PosW-1:0]    t_pos;

    // Frame types, as reported in frame_type
    typedef enum logic [1:0] {
        FT_CMD   = 2'd0,
        FT_REPLY = 2'd1,
        FT_VAR   = 2'd2,
        FT_BEAT  = 2'd3
    } t_ftype;

    // End-of-frame status codes
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_TAIL_ERR = 2'd1,
        ST_TOO_LONG = 2'd2
    } t_status;

    // Configuration register indexes
    typedef enum logic [CfgIdxW-1:0] {
        CFG_EXEC_LEN  = 2'd0,
        CFG_REPLY_LEN = 2'd1,
        CFG_BEAT_LEN  = 2'd2,
        CFG_VAR_MIN   = 2'd3
    } t_cfg_idx;

    // Header and tail words
    localparam logic [15:0] HEAD_CMD   = 16'hCAFE;
    localparam logic [15:0] HEAD_REPLY = 16'hC0DE;
    localparam logic [15:0] HEAD_VAR   = 16'h5A5A;
    localparam logic [15:0] HEAD_BEAT  = 16'hCADE;
    localparam logic [15:0] TAIL_CMD   = 16'hBABE;
    localparam logic [15:0] TAIL_REPLY = 16'hBEEF;
    localparam logic [15:0] TAIL_VAR   = 16'hAA55;
    localparam logic [15:0] TAIL_BEAT  = 16'hDEAD;

    // Reset values of the configuration registers
    localparam t_byte RST_EXEC_LEN  = 8'd20;
    localparam t_byte RST_REPLY_LEN = 8'd12;
    localparam t_byte RST_BEAT_LEN  = 8'd8;
    localparam t_byte RST_VAR_MIN   = 8'd7;

    localparam t_byte MIN_LEN = 8'd4;

    typedef struct packed {
        t_byte exec_len;
        t_byte reply_len;
        t_byte beat_len;
        t_byte var_min;
    } t_cfg;

    typedef struct packed {
        logic    is_start;
        t_ftype  frame_type;
        t_byte   frame_byte;
        t_pos    byte_index;
        logic    last;
        t_status status;
    } t_res;

    // Lengths below four are raised to four
    function automatic t_byte at_least_four(input t_byte v);
        at_least_four = (v < MIN_LEN) ? MIN_LEN : v;
    endfunction

    function automatic logic [15:0] tail_of(input t_ftype t);
        logic [15:0] w;
        unique case (t)
            FT_CMD:   w = TAIL_CMD;
            FT_REPLY: w = TAIL_REPLY;
            FT_VAR:   w = TAIL_VAR;
            FT_BEAT:  w = TAIL_BEAT;
            default:  w = TAIL_CMD;
        endcase
        tail_of = w;
    endfunction

endpackage

/* rtl/htfe_rx_if.sv */
// Input channel of the frame extractor: one received byte per beat.
// Standalone interface, no dependencies.
interface htfe_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

/* rtl/htfe_res_if.sv */
// Result channel of the frame extractor: one start or frame-byte result per beat.
// Standalone interface, no dependencies.
interface htfe_res_if;
    logic       valid;
    logic       ready;
    logic       is_start;
    logic [1:0] frame_type;
    logic [7:0] frame_byte;
    logic [7:0] byte_index;
    logic       last;
    logic [1:0] status;

    modport source (output valid, output is_start, output frame_type, output frame_byte,
                    output byte_index, output last, output status, input ready);
    modport sink   (input valid, input is_start, input frame_type, input frame_byte,
                    input byte_index, input last, input status, output ready);
endinterface

/* rtl/htfe_cfg.sv */
// Configuration register bank: frame lengths and variable-frame minimum.
// Depends on htfe_pkg.
module htfe_cfg (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [htfe_pkg::CfgIdxW-1:0]  i_cfg_idx,
    input  logic [htfe_pkg::CfgDataW-1:0] i_cfg_data,
    output htfe_pkg::t_cfg           o_cfg
);
    import htfe_pkg::*;

    t_cfg r_cfg;

    // Register writes; every index in range maps to one register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.exec_len  <= RST_EXEC_LEN;
            r_cfg.reply_len <= RST_REPLY_LEN;
            r_cfg.beat_len  <= RST_BEAT_LEN;
            r_cfg.var_min   <= RST_VAR_MIN;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_EXEC_LEN:  r_cfg.exec_len  <= i_cfg_data;
                CFG_REPLY_LEN: r_cfg.reply_len <= i_cfg_data;
                CFG_BEAT_LEN:  r_cfg.beat_len  <= i_cfg_data;
                CFG_VAR_MIN:   r_cfg.var_min   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;
endmodule

/* rtl/htfe_core.sv */
// Deframing state: header hunt, byte indexing, length and tail checks.
// Depends on htfe_pkg.
module htfe_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  htfe_pkg::t_byte i_rx_byte,
    input  htfe_pkg::t_cfg  i_cfg,
    output logic            o_res_valid,
    output htfe_pkg::t_res  o_res
);
    import htfe_pkg::*;

    logic   r_in_frame;
    t_byte  r_prev_byte;
    logic   r_prev_valid;
    t_ftype r_type;
    t_pos   r_pos;

    logic        n_in_frame;
    logic        n_prev_valid;
    t_ftype      n_type;
    t_pos        n_pos;

    logic [15:0]   pair;
    logic          head_hit;
    t_ftype        head_type;
    logic [PosW:0] pos_plus;
    t_byte         fixed_len;
    logic          done;
    t_status       status;

    assign pair     = {r_prev_byte, i_rx_byte};
    assign pos_plus = {1'b0, r_pos} + (PosW+1)'(1);

    // Header compare
    always_comb begin
        head_hit  = 1'b1;
        head_type = FT_CMD;
        priority case (pair)
            HEAD_CMD:   head_type = FT_CMD;
            HEAD_REPLY: head_type = FT_REPLY;
            HEAD_VAR:   head_type = FT_VAR;
            HEAD_BEAT:  head_type = FT_BEAT;
            default:    head_hit  = 1'b0;
        endcase
    end

    // Configured length of the current fixed frame type
    always_comb begin
        unique case (r_type)
            FT_CMD:   fixed_len = at_least_four(i_cfg.exec_len);
            FT_REPLY: fixed_len = at_least_four(i_cfg.reply_len);
            default:  fixed_len = at_least_four(i_cfg.beat_len);
        endcase
    end

    // End-of-frame decision; the length or tail wins over the overflow check
    always_comb begin
        done   = 1'b0;
        status = ST_OK;
        if (r_type == FT_VAR) begin
            if (pair == TAIL_VAR
                && pos_plus >= {1'b0, at_least_four(i_cfg.var_min)}) begin
                done = 1'b1;
            end
        end else if (pos_plus == {1'b0, fixed_len}) begin
            done   = 1'b1;
            status = (pair == tail_of(r_type)) ? ST_OK : ST_TAIL_ERR;
        end
        if (!done && pos_plus >= (PosW+1)'(MAX_FRAME_BYTES)) begin
            done   = 1'b1;
            status = ST_TOO_LONG;
        end
    end

    // Next state and result
    always_comb begin
        n_in_frame   = r_in_frame;
        n_prev_valid = 1'b1;
        n_type       = r_type;
        n_pos        = r_pos;
        o_res_valid  = 1'b0;
        o_res        = '{is_start: 1'b0, frame_type: r_type, frame_byte: i_rx_byte,
                         byte_index: r_pos, last: done, status: status};
        if (!r_in_frame) begin
            if (r_prev_valid && head_hit) begin
                o_res_valid = i_accept;
                o_res       = '{is_start: 1'b1, frame_type: head_type,
                                frame_byte: i_rx_byte, byte_index: t_pos'(1),
                                last: 1'b0, status: ST_OK};
                n_in_frame  = 1'b1;
                n_type      = head_type;
                n_pos       = t_pos'(2);
            end
        end else begin
            o_res_valid = i_accept;
            if (done) begin
                n_in_frame   = 1'b0;
                n_prev_valid = 1'b0;
                n_pos        = '0;
            end else begin
                n_pos = pos_plus[PosW-1:0];
            end
        end
    end

    // State registers, advanced once per accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame   <= 1'b0;
            r_prev_byte  <= '0;
            r_prev_valid <= 1'b0;
            r_type       <= FT_CMD;
            r_pos        <= '0;
        end else if (i_accept) begin
            r_in_frame   <= n_in_frame;
            r_prev_byte  <= i_rx_byte;
            r_prev_valid <= n_prev_valid;
            r_type       <= n_type;
            r_pos        <= n_pos;
        end
    end
endmodule

/* rtl/htfe_obuf.sv */
// Result register with a skid stage, so a new beat is taken while a result waits.
// Depends on htfe_pkg.
module htfe_obuf (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_res_valid,
    input  htfe_pkg::t_res i_res,
    output logic           o_can_take,
    output logic           o_valid,
    output htfe_pkg::t_res o_res,
    input  logic           i_ready
);
    import htfe_pkg::*;

    logic r_out_valid;
    logic r_skid_valid;
    t_res r_out;
    t_res r_skid;
    logic pop;

    assign pop        = r_out_valid && i_ready;
    assign o_can_take = !r_skid_valid;
    assign o_valid    = r_out_valid;
    assign o_res      = r_out;

    // Control: skid drains into the output register before new beats enter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (pop) begin
                r_skid_valid <= 1'b0;
            end
        end else if (i_res_valid) begin
            if (!r_out_valid || pop) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (pop) begin
            r_out_valid <= 1'b0;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (pop) begin
                r_out <= r_skid;
            end
        end else if (i_res_valid) begin
            if (!r_out_valid || pop) begin
                r_out <= i_res;
            end else begin
                r_skid <= i_res;
            end
        end
    end
endmodule

/* rtl/header_tail_frame_extractor_top.sv */
// Header/tail frame extractor: takes one received byte per beat and every cycle it
// may; each result is registered. Hunting bytes give no result; a matching header
// gives a start result, and each frame byte gives one result with its index, the
// final one flagged last with its status. The input stalls only when both the result
// register and its skid stage are full, so sustained rate is one byte per cycle while
// the result side keeps up. Configuration is to be written while idle (not enforced).
// Depends on htfe_pkg, htfe_rx_if, htfe_res_if, htfe_cfg, htfe_core and htfe_obuf.
module header_tail_frame_extractor_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [htfe_pkg::CfgIdxW-1:0]  i_cfg_idx,
    input  logic [htfe_pkg::CfgDataW-1:0] i_cfg_data,
    htfe_rx_if.sink                       i_rx,
    htfe_res_if.source                    o_res
);
    import htfe_pkg::*;

    t_cfg cfg;
    logic can_take;
    logic accept;
    logic res_valid;
    t_res res;
    t_res out_res;

    assign i_rx.ready = can_take;
    assign accept     = i_rx.valid && can_take;

    htfe_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    htfe_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_rx_byte   (i_rx.rx_byte),
        .i_cfg       (cfg),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    htfe_obuf u_obuf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .i_res       (res),
        .o_can_take  (can_take),
        .o_valid     (o_res.valid),
        .o_res       (out_res),
        .i_ready     (o_res.ready)
    );

    // Unpack the result onto the channel
    assign o_res.is_start   = out_res.is_start;
    assign o_res.frame_type = out_res.frame_type;
    assign o_res.frame_byte = out_res.frame_byte;
    assign o_res.byte_index = out_res.byte_index;
    assign o_res.last       = out_res.last;
    assign o_res.status     = out_res.status;
endmodule

/* sim/testbench.sv */
// Self-checking bench for the header/tail frame extractor: a byte-stream scoreboard
// predicts every result, random framed traffic and random stalls drive both channels.
// Depends on htfe_pkg, htfe_rx_if, htfe_res_if and header_tail_frame_extractor_top.
module testbench;
    import htfe_pkg::*;

    localparam int unsigned IDLE_LIMIT   = 3000;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned DRAIN_CYCLES = 8;

    // Deframer scoreboard: own copy of registers and hunt/frame state
    class deframe_scoreboard;
        t_byte       cmd_len;
        t_byte       reply_len;
        t_byte       beat_len;
        t_byte       var_min;
        bit          in_frame;
        t_byte       prev_byte;
        bit          prev_ok;
        t_ftype      kind;
        int unsigned pos;
        t_res        due_results[$];
        int unsigned bytes_in;
        int unsigned produced;
        int unsigned checked;
        int unsigned errors;
        int unsigned good_frames;
        int unsigned tail_errs;
        int unsigned overruns;

        function new();
            cmd_len   = RST_EXEC_LEN;
            reply_len = RST_REPLY_LEN;
            beat_len  = RST_BEAT_LEN;
            var_min   = RST_VAR_MIN;
            in_frame  = 1'b0;
            prev_byte = '0;
            prev_ok   = 1'b0;
            kind      = FT_CMD;
            pos       = 0;
        endfunction

        function void set_reg(t_cfg_idx idx, t_byte v);
            case (idx)
                CFG_EXEC_LEN:  cmd_len   = v;
                CFG_REPLY_LEN: reply_len = v;
                CFG_BEAT_LEN:  beat_len  = v;
                default:       var_min   = v;
            endcase
        endfunction

        // short lengths behave as four
        function int unsigned floor_len(t_byte v);
            return (v < MIN_LEN) ? int'(MIN_LEN) : int'(v);
        endfunction

        function int unsigned fixed_len(t_ftype k);
            case (k)
                FT_CMD:   return floor_len(cmd_len);
                FT_REPLY: return floor_len(reply_len);
                default:  return floor_len(beat_len);
            endcase
        endfunction

        function int unsigned var_floor();
            return floor_len(var_min);
        endfunction

        function logic [15:0] tail_word_for(t_ftype k);
            case (k)
                FT_CMD:   return TAIL_CMD;
                FT_REPLY: return TAIL_REPLY;
                FT_VAR:   return TAIL_VAR;
                default:  return TAIL_BEAT;
            endcase
        endfunction

        // one accepted input beat: predict its result, if any
        function void note_rx_byte(t_byte b);
            logic [15:0] word;
            t_res        r;
            bit          hit;
            bit          done;
            t_status     st;
            word = {prev_byte, b};
            bytes_in++;
            if (!in_frame) begin
                hit = 1'b0;
                if (prev_ok) begin
                    hit = 1'b1;
                    case (word)
                        HEAD_CMD:   kind = FT_CMD;
                        HEAD_REPLY: kind = FT_REPLY;
                        HEAD_VAR:   kind = FT_VAR;
                        HEAD_BEAT:  kind = FT_BEAT;
                        default:    hit = 1'b0;
                    endcase
                end
                if (hit) begin
                    in_frame     = 1'b1;
                    pos          = 2;
                    r.is_start   = 1'b1;
                    r.frame_type = kind;
                    r.frame_byte = b;
                    r.byte_index = t_pos'(1);
                    r.last       = 1'b0;
                    r.status     = ST_OK;
                    due_results.push_back(r);
                    produced++;
                end
                prev_byte = b;
                prev_ok   = 1'b1;
            end else begin
                done = 1'b0;
                st   = ST_OK;
                if (kind == FT_VAR) begin
                    if (word == TAIL_VAR && pos + 1 >= var_floor())
                        done = 1'b1;
                end else if (pos + 1 == fixed_len(kind)) begin
                    done = 1'b1;
                    st   = (word == tail_word_for(kind)) ? ST_OK : ST_TAIL_ERR;
                end
                // buffer full with no end: overrun, unless the end fell on this byte
                if (!done && pos + 1 >= MAX_FRAME_BYTES) begin
                    done = 1'b1;
                    st   = ST_TOO_LONG;
                end
                r.is_start   = 1'b0;
                r.frame_type = kind;
                r.frame_byte = b;
                r.byte_index = t_pos'(pos);
                r.last       = done;
                r.status     = st;
                due_results.push_back(r);
                produced++;
                if (done) begin
                    case (st)
                        ST_OK:       good_frames++;
                        ST_TAIL_ERR: tail_errs++;
                        default:     overruns++;
                    endcase
                    in_frame = 1'b0;
                    prev_ok  = 1'b0;
                    pos      = 0;
                end else begin
                    pos++;
                end
                prev_byte = b;
            end
        endfunction

        function int field_mismatch(string field, logic [7:0] want, logic [7:0] got);
            if (want !== got) begin
                $error("%s: expected %0d, actual %0d", field, want, got);
                return 1;
            end
            return 0;
        endfunction

        // one accepted result beat against the oldest prediction
        function void check_result(t_res got);
            t_res want;
            if (due_results.size() == 0) begin
                $error("result with nothing expected: start %0b type %0d byte %0d index %0d",
                       got.is_start, got.frame_type, got.frame_byte, got.byte_index);
                errors++;
                return;
            end
            want = due_results.pop_front();
            checked++;
            errors += field_mismatch("is_start", want.is_start, got.is_start);
            errors += field_mismatch("frame_type", want.frame_type, got.frame_type);
            errors += field_mismatch("frame_byte", want.frame_byte, got.frame_byte);
            errors += field_mismatch("byte_index", want.byte_index, got.byte_index);
            errors += field_mismatch("last", want.last, got.last);
            errors += field_mismatch("status", want.status, got.status);
        endfunction
    endclass

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [CfgIdxW-1:0]  i_cfg_idx;
    logic [CfgDataW-1:0] i_cfg_data;

    htfe_rx_if  rx_ch ();
    htfe_res_if res_ch ();

    deframe_scoreboard deframer;
    bit                hold_req    = 1'b0;
    bit                hold_done   = 1'b0;
    int unsigned       send_burst  = 0;
    int unsigned       idle_cycles = 0;

    header_tail_frame_extractor_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_rx       (rx_ch),
        .o_res      (res_ch)
    );

    always #10 i_clk = ~i_clk;

    // sender gap: mostly none, some short, a few long, occasional gap-free bursts
    function automatic int unsigned sender_gap();
        int unsigned r;
        if (send_burst > 0) begin
            send_burst--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4) begin
            send_burst = $urandom_range(20, 60);
            return 0;
        end
        if (r < 65) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 50);
    endfunction

    function automatic logic [15:0] head_of(t_ftype k);
        case (k)
            FT_CMD:   return HEAD_CMD;
            FT_REPLY: return HEAD_REPLY;
            FT_VAR:   return HEAD_VAR;
            default:  return HEAD_BEAT;
        endcase
    endfunction

    function automatic t_byte pick_len();
        if ($urandom_range(0, 99) < 85) return t_byte'($urandom_range(4, 24));
        return t_byte'($urandom_range(0, 255));
    endfunction

    // one input beat; valid stays high across back-to-back beats
    task automatic send_byte(input t_byte b);
        int unsigned gap;
        gap = sender_gap();
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        @(posedge i_clk);
        while (rx_ch.ready !== 1'b1) @(posedge i_clk);
        deframer.note_rx_byte(b);
        if (gap > 0) begin
            rx_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // one frame: header, random body, tail mostly right; or an overrun with no tail
    task automatic send_frame(input bit overrun);
        t_byte       q[$];
        t_ftype      k;
        logic [15:0] w;
        int unsigned span;
        int unsigned at;
        t_byte       b;
        k = overrun ? FT_VAR : t_ftype'($urandom_range(0, 3));
        w = head_of(k);
        q.push_back(w[15:8]);
        q.push_back(w[7:0]);
        if (overrun) begin
            // no 0xAA in the body, so no tail can form
            repeat (MAX_FRAME_BYTES - 2) begin
                b = t_byte'($urandom_range(0, 255));
                if (b == TAIL_VAR[15:8]) b = b + 8'd1;
                q.push_back(b);
            end
        end else begin
            if (k == FT_VAR) begin
                span = deframer.var_floor() + $urandom_range(0, 6);
                if (span > MAX_FRAME_BYTES) span = MAX_FRAME_BYTES;
            end else begin
                span = deframer.fixed_len(k);
            end
            repeat (span - 4) q.push_back(t_byte'($urandom_range(0, 255)));
            // an early variable tail, which may fall short of the minimum
            if (k == FT_VAR && span > 5 && $urandom_range(0, 99) < 30) begin
                at        = $urandom_range(2, span - 4);
                q[at]     = TAIL_VAR[15:8];
                q[at + 1] = TAIL_VAR[7:0];
            end
            w = deframer.tail_word_for(k);
            if ($urandom_range(0, 99) < ((k == FT_VAR) ? 8 : 20)) w = 16'($urandom);
            q.push_back(w[15:8]);
            q.push_back(w[7:0]);
        end
        foreach (q[i]) send_byte(q[i]);
    endtask

    // mostly well-formed frames, with noise and stray header bytes between them
    task automatic random_traffic(input int unsigned target, input bit overrun_first);
        int unsigned base;
        logic [15:0] w;
        base = deframer.produced;
        if (overrun_first) send_frame(1'b1);
        while (deframer.produced - base < target) begin
            repeat ($urandom_range(0, 3)) send_byte(t_byte'($urandom_range(0, 255)));
            if ($urandom_range(0, 99) < 15) begin
                w = head_of(t_ftype'($urandom_range(0, 3)));
                send_byte(w[15:8]);
            end
            if ($urandom_range(0, 99) < 90) send_frame(1'b0);
        end
    endtask

    // wait for every predicted result, then let the pipeline drain
    task automatic quiesce();
        rx_ch.valid <= 1'b0;
        while (deframer.due_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic reg_beat(input t_cfg_idx idx, input t_byte v);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= v;
        @(posedge i_clk);
        deframer.set_reg(idx, v);
    endtask

    task automatic program_regs(input t_byte cmd, input t_byte reply, input t_byte beat,
                                input t_byte vmin);
        reg_beat(CFG_EXEC_LEN, cmd);
        reg_beat(CFG_REPLY_LEN, reply);
        reg_beat(CFG_BEAT_LEN, beat);
        reg_beat(CFG_VAR_MIN, vmin);
        i_cfg_we <= 1'b0;
    endtask

    // result side: check accepted beats, random stalls and one long hold-off
    initial begin : result_sink
        t_res        got;
        int unsigned run_left;
        int unsigned stall_left;
        int unsigned r;
        run_left     = 0;
        stall_left   = 0;
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
                got = t_res'({res_ch.is_start, res_ch.frame_type, res_ch.frame_byte,
                              res_ch.byte_index, res_ch.last, res_ch.status});
                deframer.check_result(got);
            end
            if (hold_req && !hold_done) begin
                hold_done  = 1'b1;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                stall_left--;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= 1'b1;
                if (run_left > 0) begin
                    run_left--;
                end else begin
                    run_left = $urandom_range(0, 30);
                    r        = $urandom_range(0, 99);
                    if (r < 60)      stall_left = 0;
                    else if (r < 90) stall_left = $urandom_range(1, 3);
                    else if (r < 98) stall_left = $urandom_range(4, 12);
                    else             stall_left = $urandom_range(20, 60);
                end
            end
        end
    end

    // watchdog: too long without a beat on either channel
    always @(posedge i_clk) begin
        if ((rx_ch.valid === 1'b1 && rx_ch.ready === 1'b1) ||
            (res_ch.valid === 1'b1 && res_ch.ready === 1'b1)) begin
            idle_cycles = 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("testbench failed");
            $finish;
        end else begin
            idle_cycles = idle_cycles + 1;
        end
    end

    // stimulus: directed bytes, then random traffic under several register settings
    initial begin : stimulus
        t_byte directed[$];
        deframer      = new();
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= CFG_EXEC_LEN;
        i_cfg_data    <= '0;
        rx_ch.valid   <= 1'b0;
        rx_ch.rx_byte <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset lengths: byte extremes, a header behind a stray first byte, a good
        // heartbeat, a heartbeat with a bad tail ending in 0xCA, then 0xDE that
        // must not pair with it
        directed = '{8'h00, 8'hFF,
                     8'hCA, 8'hCA, 8'hDE, 8'h01, 8'h02, 8'h03, 8'h04, 8'hDE, 8'hAD,
                     8'hCA, 8'hDE, 8'h80, 8'h7F, 8'h00, 8'hFF, 8'h12, 8'hCA,
                     8'hDE};
        foreach (directed[i]) send_byte(directed[i]);
        random_traffic(300, 1'b1);

        quiesce();
        program_regs(8'd4, 8'd4, 8'd4, 8'd4);
        random_traffic(120, 1'b0);

        // lengths below four behave as four
        quiesce();
        program_regs(8'd0, 8'd1, 8'd2, 8'd3);
        random_traffic(100, 1'b0);

        // longest frames, with the long result hold-off
        quiesce();
        program_regs(8'd255, 8'd255, 8'd255, 8'd255);
        hold_req = 1'b1;
        random_traffic(200, 1'b0);

        for (int p = 0; p < 3; p++) begin
            quiesce();
            program_regs(pick_len(), pick_len(), pick_len(), pick_len());
            random_traffic(100, p == 2);
        end

        quiesce();
        $display("Run covered %0d input bytes and %0d checked results over seven settings;",
                 deframer.bytes_in, deframer.checked);
        $display("frames ended: %0d good, %0d tail mismatch, %0d overrun.",
                 deframer.good_frames, deframer.tail_errs, deframer.overruns);
        if (deframer.errors == 0 && deframer.due_results.size() == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/htfe_pkg.sv
rtl/htfe_rx_if.sv
rtl/htfe_res_if.sv
rtl/htfe_cfg.sv
rtl/htfe_core.sv
rtl/htfe_obuf.sv
rtl/header_tail_frame_extractor_top.sv
sim/testbench.sv
